/* design/base64_stream_codec_unit_defines.svh */
// ----------------------------------------------------------------------------
// base64_stream_codec_unit_defines
// Assertion macros used by the Base64 codec top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_DEFINES_SVH
`define BASE64_STREAM_CODEC_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during rst
`define B64SC_ASSERT_NOW(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("b64sc same-cycle check failed");

// next-cycle implication, clocked on clk, quiet during rst
`define B64SC_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("b64sc next-cycle check failed");

`endif

/* design/b64sc_pkg.sv */
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, codes and alphabet functions for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // job queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // job kinds
  localparam logic [1:0] KIND_ENC   = 2'd0;
  localparam logic [1:0] KIND_DEC   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // special codes from the character classifier
  localparam logic [6:0] CODE_PAD = 7'd64;
  localparam logic [6:0] CODE_BAD = 7'd65;

  // pad character '='
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // one group of work handed from front to back
  typedef struct packed {
    logic [23:0] bits;       // group bits, first result in the high bits
    logic [1:0]  kind;       // KIND_*
    logic [1:0]  nres_m1;    // number of results minus one
    logic [1:0]  valid_idx;  // encode: index of last real char, rest is '='
    logic        last;       // group closes the message
    logic        err;        // decode: bad character seen in group
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // ASCII character -> sextet, CODE_PAD for '=', CODE_BAD otherwise
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    case (c) inside
      [8'h41:8'h5A]: r = 7'(c - 8'h41);
      [8'h61:8'h7A]: r = 7'(c - 8'h47);
      [8'h30:8'h39]: r = 7'(c + 8'h04);
      8'h2B:         r = 7'd62;
      8'h2F:         r = 7'd63;
      8'h3D:         r = CODE_PAD;
      default:       r = CODE_BAD;
    endcase
    return r;
  endfunction

  // sextet -> alphabet character
  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] s8;
    logic [7:0] r;
    s8 = {2'b00, s};
    case (s) inside
      [6'd0:6'd25]:  r = s8 + 8'h41;
      [6'd26:6'd51]: r = s8 + 8'h47;
      [6'd52:6'd61]: r = s8 - 8'h04;
      6'd62:         r = 8'h2B;
      default:       r = 8'h2F;
    endcase
    return r;
  endfunction

endpackage

/* design/b64sc_front.sv */
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input words, gathers groups and pushes finished group jobs.
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  b64sc_pkg::q_status_t q_status,
  output logic                push,
  output b64sc_pkg::job_t     push_job
);

  logic        direction;
  logic [23:0] bits;
  logic [1:0]  count;
  logic        err;

  logic [23:0] bits_next;
  logic [1:0]  count_next;
  logic        err_next;
  logic        job_here;

  logic [1:0]  enc_cnt;
  logic [23:0] enc_bits;
  logic [6:0]  code;
  logic [5:0]  sx;
  logic [23:0] dec_bits;
  logic [2:0]  dec_cnt;
  logic        dec_err;
  logic        accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && job_here;

  // classify the word and build the group job
  always_comb begin
    bits_next  = bits;
    count_next = count;
    err_next   = err;
    job_here   = 1'b0;
    push_job   = '0;
    enc_cnt    = count + 2'd1;
    enc_bits   = {bits[15:0], s_tdata};
    code       = b64sc_pkg::sextet_of(s_tdata);
    sx         = 6'd0;
    dec_bits   = bits;
    dec_cnt    = {1'b0, count};
    dec_err    = err;
    if (!direction) begin
      bits_next = enc_bits;
      if (enc_cnt == 2'd3) begin
        job_here           = 1'b1;
        push_job.kind      = b64sc_pkg::KIND_ENC;
        push_job.bits      = enc_bits;
        push_job.nres_m1   = 2'd3;
        push_job.valid_idx = 2'd3;
        push_job.last      = s_tlast;
      end else if (s_tlast) begin
        job_here           = 1'b1;
        push_job.kind      = b64sc_pkg::KIND_ENC;
        push_job.bits      = (enc_cnt == 2'd1) ? {enc_bits[7:0], 16'h0000}
                                               : {enc_bits[15:0], 8'h00};
        push_job.nres_m1   = 2'd3;
        push_job.valid_idx = enc_cnt;
        push_job.last      = 1'b1;
      end else begin
        count_next = enc_cnt;
      end
    end else begin
      // '=' adds nothing; a bad character counts as zero
      if (code != b64sc_pkg::CODE_PAD) begin
        if (code == b64sc_pkg::CODE_BAD) begin
          sx      = 6'd0;
          dec_err = 1'b1;
        end else begin
          sx = code[5:0];
        end
        dec_bits = {bits[17:0], sx};
        dec_cnt  = {1'b0, count} + 3'd1;
      end
      bits_next  = dec_bits;
      count_next = dec_cnt[1:0];
      err_next   = dec_err;
      if (dec_cnt == 3'd4) begin
        job_here         = 1'b1;
        push_job.kind    = b64sc_pkg::KIND_DEC;
        push_job.bits    = dec_bits;
        push_job.nres_m1 = 2'd2;
        push_job.last    = s_tlast;
        push_job.err     = dec_err;
      end else if (s_tlast) begin
        job_here      = 1'b1;
        push_job.last = 1'b1;
        push_job.err  = dec_err;
        if (dec_cnt >= 3'd2) begin
          push_job.kind    = b64sc_pkg::KIND_DEC;
          push_job.bits    = (dec_cnt == 3'd2) ? {dec_bits[11:0], 12'h000}
                                               : {dec_bits[17:0], 6'h00};
          push_job.nres_m1 = dec_cnt[1:0] - 2'd2;
        end else begin
          push_job.kind    = b64sc_pkg::KIND_EMPTY;
          push_job.nres_m1 = 2'd0;
        end
      end
    end
    // a finished group starts over
    if (job_here) begin
      bits_next  = 24'h000000;
      count_next = 2'd0;
      err_next   = 1'b0;
    end
  end

  // direction register and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      bits      <= 24'h000000;
      count     <= 2'd0;
      err       <= 1'b0;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
      bits      <= 24'h000000;
      count     <= 2'd0;
      err       <= 1'b0;
    end else if (accept) begin
      bits  <= bits_next;
      count <= count_next;
      err   <= err_next;
    end
  end

endmodule

/* design/b64sc_queue.sv */
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module b64sc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b64sc_pkg::job_t      push_job,
  input  logic                 pop,
  output b64sc_pkg::job_t      head_job,
  output b64sc_pkg::q_status_t q_status
);

  b64sc_pkg::job_t                 slots [b64sc_pkg::QUEUE_DEPTH];
  logic [b64sc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [b64sc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [b64sc_pkg::QCNT_W-1:0]    fill;

  localparam logic [b64sc_pkg::QPTR_W-1:0] PTR_TOP =
    b64sc_pkg::QPTR_W'(b64sc_pkg::QUEUE_DEPTH - 1);
  localparam logic [b64sc_pkg::QCNT_W-1:0] FILL_FULL =
    b64sc_pkg::QCNT_W'(b64sc_pkg::QUEUE_DEPTH);

  assign head_job       = slots[rd_ptr];
  assign q_status.full  = (fill == FILL_FULL);
  assign q_status.empty = (fill == '0);

  // slot write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_TOP) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/b64sc_back.sv */
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the head job one result at a time into the output register.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  b64sc_pkg::job_t      head_job,
  input  b64sc_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [1:0]           m_tuser
);

  logic [1:0] idx;
  logic       advance;
  logic       emit;
  logic       at_end;
  logic [5:0] sextet;
  logic [7:0] byte_sel;
  logic [7:0] res_data;
  logic       res_has;
  logic       res_bad;

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && !q_status.empty;
  assign at_end  = (idx == head_job.nres_m1);
  assign pop     = emit && at_end;

  // result idx of the head job
  always_comb begin
    case (idx)
      2'd0:    sextet = head_job.bits[23:18];
      2'd1:    sextet = head_job.bits[17:12];
      2'd2:    sextet = head_job.bits[11:6];
      default: sextet = head_job.bits[5:0];
    endcase
    case (idx)
      2'd0:    byte_sel = head_job.bits[23:16];
      2'd1:    byte_sel = head_job.bits[15:8];
      default: byte_sel = head_job.bits[7:0];
    endcase
    case (head_job.kind)
      b64sc_pkg::KIND_ENC: begin
        res_data = (idx > head_job.valid_idx) ? b64sc_pkg::CHAR_PAD
                                              : b64sc_pkg::char_of(sextet);
        res_has  = 1'b1;
        res_bad  = 1'b0;
      end
      b64sc_pkg::KIND_DEC: begin
        res_data = byte_sel;
        res_has  = 1'b1;
        res_bad  = head_job.err;
      end
      default: begin
        res_data = 8'h00;
        res_has  = 1'b0;
        res_bad  = head_job.err;
      end
    endcase
  end

  // output register; tuser = {bad_char, has_data}
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= res_data;
      m_tlast <= head_job.last && at_end;
      m_tuser <= {res_bad, res_has};
    end
  end

  // result counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (advance) begin
      m_tvalid <= !q_status.empty;
      if (emit) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

/* design/base64_stream_codec_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming Base64 codec, one byte in and one byte out per word.
// ----------------------------------------------------------------------------
// Input stream s_*: one byte per word, s_tlast marks the last byte of a
// message. Output stream m_*: one character or byte per word, m_tlast on the
// final word of a message, m_tuser carries has_data and bad_char.
// cfg_we/cfg_wdata write the direction (0 encode, 1 decode) and drop any
// partial group; write only while the block is idle.
// The first result of a group passes through the job queue slot and then
// the output register once the input word that completes it is accepted.
// The output register drains one result per cycle while m_tready is high;
// encoding turns 3 bytes into 4 characters, decoding turns 4 characters
// into 3 bytes out. A two-entry job queue between the input front and the
// output serializer sets how far input runs ahead.
// Reset (rst, synchronous) clears the queue, output valid, group state and
// selects encode. When m_tready is low the output word holds; input keeps
// flowing until the job queue is full, then s_tready drops.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_defines.svh"

module base64_stream_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] has_data, [1] bad_char
);

  b64sc_pkg::job_t      push_job;
  b64sc_pkg::job_t      head_job;
  b64sc_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;

  // input side: classify and group
  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  b64sc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // output side: serialize results
  b64sc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // checks
  `B64SC_ASSERT_NOW(a_full_stalls_input, q_status.full, !s_tready)
  `B64SC_ASSERT_NOW(a_pop_needs_job, pop, !q_status.empty)
  `B64SC_ASSERT_NOW(a_empty_marker_last, m_tvalid && !m_tuser[0],
                    m_tlast && (m_tdata == 8'h00))
  `B64SC_ASSERT_NEXT(a_pop_shows_word, pop, m_tvalid)

endmodule
